FILE: src/gn2d_pkg.sv
package gn2d_pkg;

    localparam int ANGLE_BITS      = 10;
    localparam int COORD_FRAC_BITS = 8;

    localparam int COORD_W     = 24;
    localparam int IDX_W       = COORD_W - COORD_FRAC_BITS;
    localparam int HASH_W      = 32;
    localparam int NUM_CORNERS = 4;
    localparam int OUT_W       = 8;

    localparam int QTR_BITS = ANGLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    localparam int MAG_W    = 15;
    localparam int GRAD_W   = MAG_W + 1;
    localparam int OFS_W    = COORD_FRAC_BITS + 1;
    localparam int DOT_W    = 14 + COORD_FRAC_BITS + 3;
    localparam int PROD_W   = DOT_W + COORD_FRAC_BITS + 2;
    localparam int NUM_W    = DOT_W + 9;
    localparam int OUT_SHIFT = 15 + COORD_FRAC_BITS;

    localparam logic [HASH_W-1:0] HASH_MUL_A = 32'd235134323;
    localparam logic [HASH_W-1:0] HASH_MUL_B = 32'd273491234;
    localparam logic [HASH_W-1:0] HASH_MUL_C = 32'd834567342;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint HALF_SCALE  = 64'sd1 << (14 + COORD_FRAC_BITS);
    localparam logic [OUT_W-1:0] GREY_MAX = 8'd255;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef logic [2*MAG_W-1:0] grad_rom_t [QTR_SIZE];

    typedef struct packed {
        logic                                   valid;
        logic [NUM_CORNERS-1:0][ANGLE_BITS-1:0] k;
        logic [COORD_FRAC_BITS-1:0]             fx;
        logic [COORD_FRAC_BITS-1:0]             fy;
    } hash_out_t;

    typedef struct packed {
        logic                              valid;
        logic [NUM_CORNERS-1:0][DOT_W-1:0] dot;
        logic [COORD_FRAC_BITS-1:0]        fx;
        logic [COORD_FRAC_BITS-1:0]        fy;
    } dot_out_t;

    function automatic logic [HASH_W-1:0] rot16(input logic [HASH_W-1:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // quarter-wave cosine and sine, taylor series in q30, rounded to q14
    function automatic logic [2*MAG_W-1:0] grad_entry(input logic [QTR_BITS-1:0] idx);
        longint r;
        longint t;
        longint t2;
        longint h;
        longint s;
        longint c;
        r  = longint'(idx) << (16 - ANGLE_BITS);
        t  = (r * HALF_PI_Q30) >>> 14;
        t2 = q30_mul(t, t);

        h = ONE_Q30 - q30_mul(t2, ONE_Q30) / 110;
        h = ONE_Q30 - q30_mul(t2, h) / 72;
        h = ONE_Q30 - q30_mul(t2, h) / 42;
        h = ONE_Q30 - q30_mul(t2, h) / 20;
        h = ONE_Q30 - q30_mul(t2, h) / 6;
        s = q30_mul(t, h);

        h = ONE_Q30 - q30_mul(t2, ONE_Q30) / 132;
        h = ONE_Q30 - q30_mul(t2, h) / 90;
        h = ONE_Q30 - q30_mul(t2, h) / 56;
        h = ONE_Q30 - q30_mul(t2, h) / 30;
        h = ONE_Q30 - q30_mul(t2, h) / 12;
        c = ONE_Q30 - q30_mul(t2, h) / 2;

        if (s < 0)
        begin
            s = 0;
        end
        if (c < 0)
        begin
            c = 0;
        end
        s = (s + (64'sd1 << 15)) >>> 16;
        c = (c + (64'sd1 << 15)) >>> 16;
        return {c[MAG_W-1:0], s[MAG_W-1:0]};
    endfunction

    function automatic grad_rom_t build_grad_rom();
        grad_rom_t rom;
        for (int i = 0; i < QTR_SIZE; i++)
        begin
            rom[i] = grad_entry(QTR_BITS'(i));
        end
        return rom;
    endfunction

    localparam grad_rom_t GRAD_ROM = build_grad_rom();

endpackage

FILE: src/gn2d_hash.sv
module gn2d_hash (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [gn2d_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0]    y_coord,
    output gn2d_pkg::hash_out_t                    hash_out
);
    import gn2d_pkg::*;

    // stage 1: lattice indices and first multiply
    logic [HASH_W-1:0]          ix0;
    logic [HASH_W-1:0]          ix1;
    logic [HASH_W-1:0]          s1_a_next [2];
    logic [HASH_W-1:0]          s1_iy_next [2];
    logic                       s1_valid_reg;
    logic [HASH_W-1:0]          s1_a_reg [2];
    logic [HASH_W-1:0]          s1_iy_reg [2];
    logic [COORD_FRAC_BITS-1:0] s1_fx_reg;
    logic [COORD_FRAC_BITS-1:0] s1_fy_reg;

    // stage 2: second multiply per corner
    logic [HASH_W-1:0]          s2_b_next [NUM_CORNERS];
    logic                       s2_valid_reg;
    logic [HASH_W-1:0]          s2_a_reg [2];
    logic [HASH_W-1:0]          s2_b_reg [NUM_CORNERS];
    logic [COORD_FRAC_BITS-1:0] s2_fx_reg;
    logic [COORD_FRAC_BITS-1:0] s2_fy_reg;

    // stage 3: final multiply, keep angle bits
    logic [HASH_W-1:0]          s3_h_next [NUM_CORNERS];
    logic                       s3_valid_reg;
    logic [ANGLE_BITS-1:0]      s3_k_reg [NUM_CORNERS];
    logic [COORD_FRAC_BITS-1:0] s3_fx_reg;
    logic [COORD_FRAC_BITS-1:0] s3_fy_reg;

    always_comb
    begin
        ix0 = {{(HASH_W-IDX_W){x_coord[COORD_W-1]}}, x_coord[COORD_W-1:COORD_FRAC_BITS]};
        ix1 = ix0 + HASH_W'(1);
        s1_iy_next[0] = {{(HASH_W-IDX_W){y_coord[COORD_W-1]}},
                         y_coord[COORD_W-1:COORD_FRAC_BITS]};
        s1_iy_next[1] = s1_iy_next[0] + HASH_W'(1);
        s1_a_next[0]  = ix0 * HASH_MUL_A;
        s1_a_next[1]  = ix1 * HASH_MUL_A;
    end

    for (genvar g = 0; g < NUM_CORNERS; g++)
    begin : g_corner
        localparam int CX = g % 2;
        localparam int CY = g / 2;
        assign s2_b_next[g] = (s1_iy_reg[CY] ^ rot16(s1_a_reg[CX])) * HASH_MUL_B;
        assign s3_h_next[g] = (s2_a_reg[CX] ^ rot16(s2_b_reg[g])) * HASH_MUL_C;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_a_reg  <= s1_a_next;
            s1_iy_reg <= s1_iy_next;
            s1_fx_reg <= x_coord[COORD_FRAC_BITS-1:0];
            s1_fy_reg <= y_coord[COORD_FRAC_BITS-1:0];
        end
        if (s1_valid_reg)
        begin
            s2_a_reg  <= s1_a_reg;
            s2_b_reg  <= s2_b_next;
            s2_fx_reg <= s1_fx_reg;
            s2_fy_reg <= s1_fy_reg;
        end
        if (s2_valid_reg)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                s3_k_reg[c] <= s3_h_next[c][HASH_W-1 -: ANGLE_BITS];
            end
            s3_fx_reg <= s2_fx_reg;
            s3_fy_reg <= s2_fy_reg;
        end
    end

    always_comb
    begin
        hash_out.valid = s3_valid_reg;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            hash_out.k[c] = s3_k_reg[c];
        end
        hash_out.fx = s3_fx_reg;
        hash_out.fy = s3_fy_reg;
    end

endmodule

FILE: src/gn2d_grad.sv
module gn2d_grad (
    input  logic                clk,
    input  logic                rst_n,
    input  gn2d_pkg::hash_out_t hash_in,
    output gn2d_pkg::dot_out_t  dot_out
);
    import gn2d_pkg::*;

    // stage 4: gradient lookup
    logic signed [GRAD_W-1:0]   s4_gx_next [NUM_CORNERS];
    logic signed [GRAD_W-1:0]   s4_gy_next [NUM_CORNERS];
    logic                       s4_valid_reg;
    logic signed [GRAD_W-1:0]   s4_gx_reg [NUM_CORNERS];
    logic signed [GRAD_W-1:0]   s4_gy_reg [NUM_CORNERS];
    logic [COORD_FRAC_BITS-1:0] s4_fx_reg;
    logic [COORD_FRAC_BITS-1:0] s4_fy_reg;

    // stage 5: dot products with corner offsets
    logic signed [DOT_W-1:0]    s5_dot_next [NUM_CORNERS];
    logic                       s5_valid_reg;
    logic signed [DOT_W-1:0]    s5_dot_reg [NUM_CORNERS];
    logic [COORD_FRAC_BITS-1:0] s5_fx_reg;
    logic [COORD_FRAC_BITS-1:0] s5_fy_reg;

    for (genvar g = 0; g < NUM_CORNERS; g++)
    begin : g_corner
        localparam logic XBIT = 1'(g % 2);
        localparam logic YBIT = 1'(g / 2);

        logic [2*MAG_W-1:0]       rom_word;
        logic signed [GRAD_W-1:0] mag_c;
        logic signed [GRAD_W-1:0] mag_s;
        logic signed [OFS_W-1:0]  dx;
        logic signed [OFS_W-1:0]  dy;

        assign rom_word = GRAD_ROM[hash_in.k[g][QTR_BITS-1:0]];
        assign mag_c    = signed'({1'b0, rom_word[2*MAG_W-1:MAG_W]});
        assign mag_s    = signed'({1'b0, rom_word[MAG_W-1:0]});

        // quadrant rotates the first-quadrant pair
        always_comb
        begin
            unique case (quad_t'(hash_in.k[g][ANGLE_BITS-1 -: 2]))
                QUAD_0:
                begin
                    s4_gx_next[g] = mag_c;
                    s4_gy_next[g] = mag_s;
                end
                QUAD_1:
                begin
                    s4_gx_next[g] = -mag_s;
                    s4_gy_next[g] = mag_c;
                end
                QUAD_2:
                begin
                    s4_gx_next[g] = -mag_c;
                    s4_gy_next[g] = -mag_s;
                end
                QUAD_3:
                begin
                    s4_gx_next[g] = mag_s;
                    s4_gy_next[g] = -mag_c;
                end
            endcase
        end

        // far corner offset is fraction minus one
        assign dx = signed'({XBIT, s4_fx_reg});
        assign dy = signed'({YBIT, s4_fy_reg});
        assign s5_dot_next[g] = DOT_W'(s4_gx_reg[g]) * DOT_W'(dx)
                              + DOT_W'(s4_gy_reg[g]) * DOT_W'(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= hash_in.valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_in.valid)
        begin
            s4_gx_reg <= s4_gx_next;
            s4_gy_reg <= s4_gy_next;
            s4_fx_reg <= hash_in.fx;
            s4_fy_reg <= hash_in.fy;
        end
        if (s4_valid_reg)
        begin
            s5_dot_reg <= s5_dot_next;
            s5_fx_reg  <= s4_fx_reg;
            s5_fy_reg  <= s4_fy_reg;
        end
    end

    always_comb
    begin
        dot_out.valid = s5_valid_reg;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            dot_out.dot[c] = s5_dot_reg[c];
        end
        dot_out.fx = s5_fx_reg;
        dot_out.fy = s5_fy_reg;
    end

endmodule

FILE: src/gn2d_blend.sv
module gn2d_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gn2d_pkg::dot_out_t            dot_in,
    output logic [gn2d_pkg::OUT_W-1:0]    noise_value,
    output logic                          done
);
    import gn2d_pkg::*;

    function automatic logic signed [DOT_W-1:0] lerp(
        input logic signed [DOT_W-1:0]   n0,
        input logic signed [DOT_W-1:0]   n1,
        input logic [COORD_FRAC_BITS-1:0] w
    );
        logic signed [PROD_W-1:0] p;
        p = (PROD_W'(n1) - PROD_W'(n0)) * PROD_W'(signed'({1'b0, w}));
        return n0 + DOT_W'(p >>> COORD_FRAC_BITS);
    endfunction

    // stage 6: blend along x
    logic signed [DOT_W-1:0]    s6_i_next [2];
    logic                       s6_valid_reg;
    logic signed [DOT_W-1:0]    s6_i_reg [2];
    logic [COORD_FRAC_BITS-1:0] s6_fy_reg;

    // stage 7: blend along y
    logic signed [DOT_W-1:0]    s7_v_next;
    logic                       s7_valid_reg;
    logic signed [DOT_W-1:0]    s7_v_reg;

    // stage 8: scale and clamp to grey level
    logic signed [NUM_W-1:0]    num;
    logic [OUT_W-1:0]           noise_next;
    logic                       done_reg;
    logic [OUT_W-1:0]           noise_reg;

    always_comb
    begin
        s6_i_next[0] = lerp(signed'(dot_in.dot[0]), signed'(dot_in.dot[1]), dot_in.fx);
        s6_i_next[1] = lerp(signed'(dot_in.dot[2]), signed'(dot_in.dot[3]), dot_in.fx);
        s7_v_next    = lerp(s6_i_reg[0], s6_i_reg[1], s6_fy_reg);
    end

    always_comb
    begin
        num = (NUM_W'(s7_v_reg) + NUM_W'(HALF_SCALE)) * NUM_W'(signed'({1'b0, GREY_MAX}));
        priority if (num[NUM_W-1])
        begin
            noise_next = '0;
        end
        else if (|num[NUM_W-2:OUT_SHIFT+OUT_W])
        begin
            noise_next = GREY_MAX;
        end
        else
        begin
            noise_next = num[OUT_SHIFT +: OUT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= dot_in.valid;
            s7_valid_reg <= s6_valid_reg;
            done_reg     <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dot_in.valid)
        begin
            s6_i_reg  <= s6_i_next;
            s6_fy_reg <= dot_in.fy;
        end
        if (s6_valid_reg)
        begin
            s7_v_reg <= s7_v_next;
        end
        if (s7_valid_reg)
        begin
            noise_reg <= noise_next;
        end
    end

    assign noise_value = noise_reg;
    assign done        = done_reg;

endmodule

FILE: src/gradient_noise_2d_sample.sv
// 2d gradient noise, one grey-level sample per coordinate
//
// input: pulse start with x_coord and y_coord (signed, 8 fraction bits);
// the item is taken at the clock edge where start is high and busy is low.
// busy stays low, so a new item may be given in every cycle.
//
// output: done is high for exactly one cycle with noise_value (0..255)
// valid in that same cycle; the receiver has no way to hold it off.
//
// throughput: one item per cycle, set by an eight-stage pipeline:
// three hash multiply stages, gradient table lookup, dot products,
// blend along x, blend along y, scale and clamp.
//
// reset: asynchronous, active low; clears the stage valid bits so no
// stray done appears. items in flight at reset are dropped.
module gradient_noise_2d_sample (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gn2d_pkg::COORD_W-1:0] x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0] y_coord,
    output logic [gn2d_pkg::OUT_W-1:0]          noise_value,
    output logic                                done
);
    import gn2d_pkg::*;

    logic      in_valid;
    hash_out_t hash_out;
    dot_out_t  dot_out;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    gn2d_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .hash_out (hash_out)
    );

    gn2d_grad u_grad (
        .clk     (clk),
        .rst_n   (rst_n),
        .hash_in (hash_out),
        .dot_out (dot_out)
    );

    gn2d_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .dot_in      (dot_out),
        .noise_value (noise_value),
        .done        (done)
    );

endmodule

FILE: test/noise_sample_checker.sv
`timescale 1ns / 1ps

module noise_sample_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [gn2d_pkg::COORD_W-1:0] x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0] y_coord,
    input  logic [gn2d_pkg::OUT_W-1:0]          noise_value,
    input  logic                                done,
    output int                                  errors,
    output int                                  pending,
    output int                                  checked,
    output int                                  clipped
);
    import gn2d_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [OUT_W-1:0]          grey;
    } sample_t;

    sample_t grey_due [$];
    sample_t head;
    int      fail_total;
    int      seen_total;
    int      clip_total;

    longint sine_div [5] = '{110, 72, 42, 20, 6};
    longint cosine_div [5] = '{132, 90, 56, 30, 12};

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [HASH_W-1:0] lattice_hash(input logic [HASH_W-1:0] ix,
                                                       input logic [HASH_W-1:0] iy);
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        a = ix * HASH_MUL_A;
        b = iy ^ {a[15:0], a[31:16]};
        b = b * HASH_MUL_B;
        a = a ^ {b[15:0], b[31:16]};
        a = a * HASH_MUL_C;
        return a;
    endfunction

    // unit gradient in q14 for one angle step
    function automatic void unit_gradient(input logic [ANGLE_BITS-1:0] k,
                                          output longint gx, output longint gy);
        longint r;
        longint t;
        longint t2;
        longint h;
        longint s;
        longint c;
        r  = longint'(k[ANGLE_BITS-3:0]) << (16 - ANGLE_BITS);
        t  = (r * HALF_PI_Q30) >>> 14;
        t2 = mul_q30(t, t);
        h  = ONE_Q30;
        for (int i = 0; i < 5; i++)
        begin
            h = ONE_Q30 - mul_q30(t2, h) / sine_div[i];
        end
        s = mul_q30(t, h);
        h = ONE_Q30;
        for (int i = 0; i < 5; i++)
        begin
            h = ONE_Q30 - mul_q30(t2, h) / cosine_div[i];
        end
        c = ONE_Q30 - mul_q30(t2, h) / 2;
        if (s < 0)
        begin
            s = 0;
        end
        if (c < 0)
        begin
            c = 0;
        end
        s = (s + (64'sd1 << 15)) >>> 16;
        c = (c + (64'sd1 << 15)) >>> 16;
        case (quad_t'(k[ANGLE_BITS-1 -: 2]))
            QUAD_0:
            begin
                gx = c;
                gy = s;
            end
            QUAD_1:
            begin
                gx = -s;
                gy = c;
            end
            QUAD_2:
            begin
                gx = -c;
                gy = -s;
            end
            default:
            begin
                gx = s;
                gy = -c;
            end
        endcase
    endfunction

    function automatic longint corner_dot(input longint ix, input longint iy,
                                          input longint dx, input longint dy);
        logic [HASH_W-1:0] h;
        longint            gx;
        longint            gy;
        h = lattice_hash(ix[31:0], iy[31:0]);
        unit_gradient(h[HASH_W-1 -: ANGLE_BITS], gx, gy);
        return gx * dx + gy * dy;
    endfunction

    function automatic longint lerp_q(input longint a, input longint b, input longint w);
        return a + (((b - a) * w) >>> COORD_FRAC_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] noise_grey(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        longint one_f;
        longint xs;
        longint ys;
        longint fx;
        longint fy;
        longint x0;
        longint y0;
        longint row0;
        longint row1;
        longint v;
        longint num;
        one_f = 64'sd1 << COORD_FRAC_BITS;
        xs    = longint'(x);
        ys    = longint'(y);
        fx    = xs & (one_f - 1);
        fy    = ys & (one_f - 1);
        x0    = (xs - fx) >>> COORD_FRAC_BITS;
        y0    = (ys - fy) >>> COORD_FRAC_BITS;
        row0  = lerp_q(corner_dot(x0, y0, fx, fy),
                       corner_dot(x0 + 1, y0, fx - one_f, fy), fx);
        row1  = lerp_q(corner_dot(x0, y0 + 1, fx, fy - one_f),
                       corner_dot(x0 + 1, y0 + 1, fx - one_f, fy - one_f), fx);
        v     = lerp_q(row0, row1, fy);
        num   = (v + (64'sd1 << (14 + COORD_FRAC_BITS))) * 255;
        if (num < 0)
        begin
            num = 0;
        end
        else
        begin
            num = num >>> (15 + COORD_FRAC_BITS);
        end
        if (num > 255)
        begin
            num = 255;
        end
        return num[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grey_due.delete();
            fail_total = 0;
            seen_total = 0;
            clip_total = 0;
            errors     <= 0;
            pending    <= 0;
            checked    <= 0;
            clipped    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (grey_due.size() == 0)
                begin
                    if (fail_total < 10)
                    begin
                        $display("%0t: unexpected sample %0d with nothing outstanding",
                                 $realtime, noise_value);
                    end
                    fail_total++;
                end
                else
                begin
                    head = grey_due.pop_front();
                    seen_total++;
                    if (head.grey == 8'd0 || head.grey == GREY_MAX)
                    begin
                        clip_total++;
                    end
                    if (noise_value !== head.grey)
                    begin
                        if (fail_total < 10)
                        begin
                            $display("%0t: x=%0d y=%0d noise_value expected %0d got %0d",
                                     $realtime, head.x, head.y, head.grey, noise_value);
                        end
                        fail_total++;
                    end
                end
            end
            if (start && !busy)
            begin
                grey_due.push_back('{x_coord, y_coord, noise_grey(x_coord, y_coord)});
            end
            errors  <= fail_total;
            pending <= grey_due.size();
            checked <= seen_total;
            clipped <= clip_total;
        end
    end

endmodule

FILE: test/gradient_noise_2d_sample_tb.sv
`timescale 1ns / 1ps

module gradient_noise_2d_sample_tb;

    import gn2d_pkg::*;

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 750;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [OUT_W-1:0]          noise_value;
    logic                      done;

    int errors;
    int pending;
    int checked;
    int clipped;
    int sent;
    int burst_left;
    bit no_gaps;

    logic [COORD_W-1:0] dir_x [N_DIRECTED] = '{
        24'h000000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
        24'hFFFFFF, 24'h0000FF, 24'h000080, 24'hFFFF80, 24'h000100,
        24'h555555, 24'hAAAAAA, 24'h000001, 24'h000000, 24'hFFFD11,
        24'h7FFF00, 24'h000000, 24'h7FFFFF, 24'hFFFF01, 24'h8000FF
    };
    logic [COORD_W-1:0] dir_y [N_DIRECTED] = '{
        24'h000000, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
        24'hFFFFFF, 24'h0000FF, 24'h000080, 24'hFFFF7F, 24'hFFFF00,
        24'hAAAAAA, 24'h555555, 24'h000000, 24'h000001, 24'h000028,
        24'h800000, 24'hFFFFFF, 24'h000000, 24'h7FFF01, 24'hFFFF00
    };

    gradient_noise_2d_sample uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .noise_value (noise_value),
        .done        (done)
    );

    noise_sample_checker grey_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .noise_value (noise_value),
        .done        (done),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .clipped     (clipped)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [COORD_W-1:0] pick_coord();
        int          mode;
        logic [31:0] r;
        mode = $urandom_range(0, 9);
        r    = $urandom();
        case (mode)
            0, 1, 2, 3, 4, 5:
            begin
                return COORD_W'($urandom_range(0, 16383)) - COORD_W'(8192);
            end
            6, 7:
            begin
                return r[COORD_W-1:0];
            end
            8:
            begin
                // fraction at the cell borders
                case (r[1:0])
                    2'd0:    return {r[COORD_W-1:COORD_FRAC_BITS], 8'h00};
                    2'd1:    return {r[COORD_W-1:COORD_FRAC_BITS], 8'h01};
                    2'd2:    return {r[COORD_W-1:COORD_FRAC_BITS], 8'hFE};
                    default: return {r[COORD_W-1:COORD_FRAC_BITS], 8'hFF};
                endcase
            end
            default:
            begin
                // near the ends of the coordinate range
                if (r[31])
                begin
                    return 24'h7FFFFF - COORD_W'($urandom_range(0, 1023));
                end
                return 24'h800000 + COORD_W'($urandom_range(0, 1023));
            end
        endcase
    endfunction

    task automatic send_item(input logic [COORD_W-1:0] xv, input logic [COORD_W-1:0] yv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(10, 60);
            no_gaps    = ($urandom_range(0, 2) == 0);
        end
        burst_left--;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        x_coord <= xv;
        y_coord <= yv;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sent++;
    endtask

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        x_coord    = '0;
        y_coord    = '0;
        sent       = 0;
        burst_left = 0;
        no_gaps    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_item(dir_x[i], dir_y[i]);
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            send_item(pick_coord(), pick_coord());
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("%0d coordinates sent (%0d directed), %0d samples checked",
                 sent, N_DIRECTED, checked);
        $display("%0d samples at a grey-level limit, %0d failures", clipped, errors);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
